### rtl/core/chr_pkg.sv
package chr_pkg;

    typedef enum logic [2:0] {
        OP_BYTE   = 3'd0,
        OP_COMMIT = 3'd1,
        OP_OLDER  = 3'd2,
        OP_NEWER  = 3'd3,
        OP_LEAVE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        K_ADDED    = 3'd0,
        K_INVALID  = 3'd1,
        K_DUP      = 3'd2,
        K_BYTE     = 3'd3,
        K_CLEARED  = 3'd4,
        K_NOCHANGE = 3'd5,
        K_LEFT     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        SCAN_AFTER,
        SCAN_NEWEST,
        SCAN_BEFORE
    } scan_mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_RECALL,
        S_RC_RD,
        S_RC_CHK,
        S_RC_END,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_NEWER_DEC,
        S_DUP_START,
        S_DUP_TERM,
        S_CMP_RD,
        S_CMP_CHK,
        S_EVICT_CHK,
        S_EVICT_START,
        S_MOVE_RD,
        S_MOVE_WR,
        S_APP_RD,
        S_APP_WR,
        S_APP_TERM
    } state_t;

endpackage

### rtl/core/chr_ram.sv
module chr_ram
    import chr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/command_history_ring_unit.sv
// Command line history buffer.
// Request channel: a request (opcode, line_byte) is taken on a rising edge
// with start high and busy low. Opcodes: stage a line byte, commit the line,
// recall older, recall newer, leave navigation.
// Result channel: each result shows on kind, recalled_byte, byte_index and
// last for one cycle with strobe high; the receiver cannot stall it, so it
// must sample every strobe. last marks the final result of a request.
// Answers: line byte, leave, unused opcodes and requests refused up front
// (invalid commit, nothing to walk) answer in the cycle after the request,
// with busy staying low. Commit and recall run on a small sequencer around a
// shared byte compare/increment unit and the history RAM's single read port:
// a recall walks the store up to its current fill, copies the entry into the
// staged line and streams it byte by byte, reading each byte before it is
// sent; a commit walks the store once for the newest entry, compares, then
// per evicted entry walks and compacts the store, then appends the line. The
// longest request is a long line that evicts many short entries. busy is
// high throughout.
// Reset: history and staged line become empty, navigation off. The RAMs
// need no clearing pass; only written bytes are ever read.
module command_history_ring_unit
    import chr_pkg::*;
#(
    parameter int HISTORY_BYTES = 256,
    parameter int LINE_BYTES    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [7:0] line_byte,
    output logic       strobe,
    output logic [2:0] kind,
    output logic [7:0] recalled_byte,
    output logic [5:0] byte_index,
    output logic       last
);

    localparam int HA  = $clog2(HISTORY_BYTES);
    localparam int UW  = $clog2(HISTORY_BYTES + 1);
    localparam int SW  = UW + 1;
    localparam int LA  = $clog2(LINE_BYTES);
    localparam int LW1 = $clog2(LINE_BYTES + 1);

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    scan_mode_t       mode_reg, mode_next;
    logic [UW-1:0]    used_reg, used_next;
    logic [UW-1:0]    nav_off_reg, nav_off_next;
    logic             nav_act_reg, nav_act_next;
    logic [LW1-1:0]   slen_reg, slen_next;
    logic             sovf_reg, sovf_next;
    logic             sterm_reg, sterm_next;
    logic [UW-1:0]    idx_reg, idx_next;
    logic [UW-1:0]    start_reg, start_next;
    logic [UW-1:0]    res_reg, res_next;
    logic [UW-1:0]    dst_reg, dst_next;
    logic [LW1-1:0]   k_reg, k_next;
    logic             strobe_reg, strobe_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic [5:0]       bidx_reg, bidx_next;
    logic             last_reg, last_next;

    // History store and staged line RAMs
    logic          h_we;
    logic [HA-1:0] h_waddr, h_raddr;
    logic [7:0]    h_wdata, hd;
    logic          s_we;
    logic [LA-1:0] s_waddr;
    logic [7:0]    s_wdata, sd;

    chr_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (hd)
    );

    chr_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_stage (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (k_reg[LA-1:0]),
        .rdata (sd)
    );

    // Shared compare/increment unit
    logic          accept;
    logic          hz;
    logic [UW-1:0] idx_inc;
    logic          scan_end;
    logic          scan_stop;
    logic          start_upd;
    logic [SW-1:0] l_ext;
    logic [SW-1:0] used_ext;
    logic [SW-1:0] res_l;
    logic [SW-1:0] res_k;
    logic [SW-1:0] used_k;
    logic [SW-1:0] used_l;
    logic          commit_bad;
    logic          need_evict;
    logic          emit_last;
    logic          rc_more;

    assign accept   = start && !busy;
    assign hz       = (hd == 8'd0);
    assign idx_inc  = idx_reg + 1'b1;
    assign scan_end = (idx_reg >= used_reg);
    assign l_ext    = SW'(slen_reg);
    assign used_ext = {1'b0, used_reg};
    assign res_l    = {1'b0, res_reg} + l_ext;
    assign res_k    = {1'b0, res_reg} + SW'(k_reg);
    assign used_k   = used_ext + SW'(k_reg);
    assign used_l   = used_ext + l_ext;
    assign need_evict = (used_l + 1'b1) > SW'(HISTORY_BYTES);
    assign commit_bad = (slen_reg == '0) || sovf_reg || (slen_reg >= LW1'(LINE_BYTES))
                        || ((l_ext + 1'b1) > SW'(HISTORY_BYTES));
    assign emit_last = ((k_reg + 1'b1) == slen_reg);
    assign rc_more   = (k_reg < LW1'(LINE_BYTES - 1)) && (idx_reg < used_reg);

    always_comb
    begin
        scan_stop = 1'b0;
        start_upd = 1'b0;
        unique case (mode_reg)
            SCAN_AFTER:
            begin
                scan_stop = hz;
            end
            SCAN_NEWEST:
            begin
                start_upd = hz && (idx_inc < used_reg);
            end
            SCAN_BEFORE:
            begin
                scan_stop = hz && ((idx_inc >= nav_off_reg) || (idx_inc >= used_reg));
                start_upd = hz && !scan_stop;
            end
            default:
            begin
                scan_stop = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_COMMIT:
                        begin
                            if (commit_bad)
                                state_next = S_IDLE;
                            else if (used_reg != '0)
                                state_next = S_SCAN;
                            else
                                state_next = S_EVICT_CHK;
                        end
                        OP_OLDER:
                        begin
                            if (used_reg == '0 || (nav_act_reg && nav_off_reg == '0))
                                state_next = S_IDLE;
                            else
                                state_next = S_SCAN;
                        end
                        OP_NEWER:
                            state_next = nav_act_reg ? S_SCAN : S_IDLE;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:        state_next = scan_end ? ret_reg : S_SCAN_CHK;
            S_SCAN_CHK:    state_next = scan_stop ? ret_reg : S_SCAN;
            S_RECALL:      state_next = S_RC_RD;
            S_RC_RD:       state_next = rc_more ? S_RC_CHK : S_RC_END;
            S_RC_CHK:      state_next = hz ? S_RC_END : S_RC_RD;
            S_RC_END:      state_next = (k_reg == '0) ? S_IDLE : S_EMIT_RD;
            S_EMIT_RD:     state_next = S_EMIT_OUT;
            S_EMIT_OUT:    state_next = emit_last ? S_IDLE : S_EMIT_RD;
            S_NEWER_DEC:   state_next = (res_reg < used_reg) ? S_RECALL : S_IDLE;
            S_DUP_START:   state_next = (res_l < used_ext) ? S_DUP_TERM : S_EVICT_CHK;
            S_DUP_TERM:    state_next = hz ? S_CMP_RD : S_EVICT_CHK;
            S_CMP_RD:      state_next = (k_reg == slen_reg) ? S_IDLE : S_CMP_CHK;
            S_CMP_CHK:     state_next = (hd == sd) ? S_CMP_RD : S_EVICT_CHK;
            S_EVICT_CHK:   state_next = need_evict ? S_SCAN : S_APP_RD;
            S_EVICT_START: state_next = (res_reg == '0) ? S_APP_RD : S_MOVE_RD;
            S_MOVE_RD:     state_next = (idx_reg < used_reg) ? S_MOVE_WR : S_EVICT_CHK;
            S_MOVE_WR:     state_next = S_MOVE_RD;
            S_APP_RD:      state_next = (k_reg < slen_reg) ? S_APP_WR : S_APP_TERM;
            S_APP_WR:      state_next = S_APP_RD;
            S_APP_TERM:    state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM ports and results
    always_comb
    begin
        ret_next     = ret_reg;
        mode_next    = mode_reg;
        used_next    = used_reg;
        nav_off_next = nav_off_reg;
        nav_act_next = nav_act_reg;
        slen_next    = slen_reg;
        sovf_next    = sovf_reg;
        sterm_next   = sterm_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        res_next     = res_reg;
        dst_next     = dst_reg;
        k_next       = k_reg;
        strobe_next  = 1'b0;
        kind_next    = K_NOCHANGE;
        byte_next    = 8'd0;
        bidx_next    = 6'd0;
        last_next    = 1'b0;
        h_we         = 1'b0;
        h_waddr      = dst_reg[HA-1:0];
        h_wdata      = hd;
        h_raddr      = idx_reg[HA-1:0];
        s_we         = 1'b0;
        s_waddr      = k_reg[LA-1:0];
        s_wdata      = hd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    kind_next   = K_NOCHANGE;
                    case (opcode)
                        OP_BYTE:
                        begin
                            // Stage a byte; zero terminates, excess flags overflow
                            if (!sterm_reg)
                            begin
                                if (line_byte == 8'd0)
                                    sterm_next = 1'b1;
                                else if (slen_reg < LW1'(LINE_BYTES))
                                begin
                                    s_we      = 1'b1;
                                    s_waddr   = slen_reg[LA-1:0];
                                    s_wdata   = line_byte;
                                    slen_next = slen_reg + 1'b1;
                                end
                                else
                                    sovf_next = 1'b1;
                            end
                        end
                        OP_COMMIT:
                        begin
                            if (commit_bad)
                            begin
                                kind_next  = K_INVALID;
                                slen_next  = '0;
                                sovf_next  = 1'b0;
                                sterm_next = 1'b0;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                last_next   = 1'b0;
                                idx_next    = '0;
                                start_next  = '0;
                                mode_next   = SCAN_NEWEST;
                                ret_next    = S_DUP_START;
                            end
                        end
                        OP_OLDER:
                        begin
                            if (!(used_reg == '0 || (nav_act_reg && nav_off_reg == '0)))
                            begin
                                strobe_next = 1'b0;
                                last_next   = 1'b0;
                                idx_next    = '0;
                                start_next  = '0;
                                mode_next   = nav_act_reg ? SCAN_BEFORE : SCAN_NEWEST;
                                ret_next    = S_RECALL;
                            end
                        end
                        OP_NEWER:
                        begin
                            if (nav_act_reg)
                            begin
                                strobe_next = 1'b0;
                                last_next   = 1'b0;
                                idx_next    = nav_off_reg;
                                mode_next   = SCAN_AFTER;
                                ret_next    = S_NEWER_DEC;
                            end
                        end
                        OP_LEAVE:
                        begin
                            kind_next    = K_LEFT;
                            nav_act_next = 1'b0;
                            nav_off_next = '0;
                        end
                        default:
                        begin
                            kind_next = K_NOCHANGE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Past the fill: after-scan lands on the fill, others on the last start
                if (scan_end)
                    res_next = (mode_reg == SCAN_AFTER) ? used_reg : start_reg;
            end
            S_SCAN_CHK:
            begin
                if (start_upd)
                    start_next = idx_inc;
                if (scan_stop)
                    res_next = (mode_reg == SCAN_AFTER) ? idx_inc : start_reg;
                idx_next = idx_inc;
            end
            S_RECALL:
            begin
                nav_off_next = res_reg;
                nav_act_next = 1'b1;
                idx_next     = res_reg;
                k_next       = '0;
            end
            S_RC_CHK:
            begin
                // Copy the entry into the live line
                if (!hz)
                begin
                    s_we     = 1'b1;
                    s_waddr  = k_reg[LA-1:0];
                    s_wdata  = hd;
                    k_next   = k_reg + 1'b1;
                    idx_next = idx_inc;
                end
            end
            S_RC_END:
            begin
                slen_next  = k_reg;
                sovf_next  = 1'b0;
                sterm_next = 1'b0;
                k_next     = '0;
                if (k_reg == '0)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    kind_next   = K_NOCHANGE;
                end
            end
            S_EMIT_OUT:
            begin
                strobe_next = 1'b1;
                kind_next   = K_BYTE;
                byte_next   = sd;
                bidx_next   = 6'(k_reg);
                last_next   = emit_last;
                k_next      = k_reg + 1'b1;
            end
            S_NEWER_DEC:
            begin
                if (!(res_reg < used_reg))
                begin
                    nav_act_next = 1'b0;
                    slen_next    = '0;
                    sovf_next    = 1'b0;
                    sterm_next   = 1'b0;
                    strobe_next  = 1'b1;
                    last_next    = 1'b1;
                    kind_next    = K_CLEARED;
                end
            end
            S_DUP_START:
            begin
                h_raddr = res_l[HA-1:0];
                k_next  = '0;
            end
            S_CMP_RD:
            begin
                h_raddr = res_k[HA-1:0];
                if (k_reg == slen_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    kind_next   = K_DUP;
                    slen_next   = '0;
                    sovf_next   = 1'b0;
                    sterm_next  = 1'b0;
                end
            end
            S_CMP_CHK:
            begin
                k_next = k_reg + 1'b1;
            end
            S_EVICT_CHK:
            begin
                k_next = '0;
                if (need_evict)
                begin
                    idx_next  = '0;
                    start_next = '0;
                    mode_next = SCAN_AFTER;
                    ret_next  = S_EVICT_START;
                end
            end
            S_EVICT_START:
            begin
                // Shift the store down over the oldest entry
                idx_next = res_reg;
                dst_next = '0;
            end
            S_MOVE_RD:
            begin
                if (!(idx_reg < used_reg))
                    used_next = dst_reg;
            end
            S_MOVE_WR:
            begin
                h_we     = 1'b1;
                h_waddr  = dst_reg[HA-1:0];
                h_wdata  = hd;
                idx_next = idx_inc;
                dst_next = dst_reg + 1'b1;
            end
            S_APP_WR:
            begin
                h_we    = 1'b1;
                h_waddr = used_k[HA-1:0];
                h_wdata = sd;
                k_next  = k_reg + 1'b1;
            end
            S_APP_TERM:
            begin
                h_we        = 1'b1;
                h_waddr     = used_l[HA-1:0];
                h_wdata     = 8'd0;
                used_next   = UW'(used_l + 1'b1);
                slen_next   = '0;
                sovf_next   = 1'b0;
                sterm_next  = 1'b0;
                strobe_next = 1'b1;
                last_next   = 1'b1;
                kind_next   = K_ADDED;
            end
            default:
            begin
                h_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            mode_reg    <= SCAN_AFTER;
            used_reg    <= '0;
            nav_off_reg <= '0;
            nav_act_reg <= 1'b0;
            slen_reg    <= '0;
            sovf_reg    <= 1'b0;
            sterm_reg   <= 1'b0;
            idx_reg     <= '0;
            start_reg   <= '0;
            res_reg     <= '0;
            dst_reg     <= '0;
            k_reg       <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            mode_reg    <= mode_next;
            used_reg    <= used_next;
            nav_off_reg <= nav_off_next;
            nav_act_reg <= nav_act_next;
            slen_reg    <= slen_next;
            sovf_reg    <= sovf_next;
            sterm_reg   <= sterm_next;
            idx_reg     <= idx_next;
            start_reg   <= start_next;
            res_reg     <= res_next;
            dst_reg     <= dst_next;
            k_reg       <= k_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Result payload holds no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        bidx_reg <= bidx_next;
        last_reg <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = strobe_reg;
    assign kind          = kind_reg;
    assign recalled_byte = byte_reg;
    assign byte_index    = bidx_reg;
    assign last          = last_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(HISTORY_BYTES))
        else $error("history fill beyond store size");

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slen_reg <= LW1'(LINE_BYTES))
        else $error("staged length beyond line size");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind != K_BYTE) |-> last)
        else $error("single result without last");

    a_byte_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_BYTE) |=> (strobe && last && kind == K_NOCHANGE))
        else $error("line byte request not answered next cycle");
`endif

endmodule
